/* rtl/partial_permutation_rank_defines.svh */
// Assertion macros shared by the checker of the partial permutation ranker.
// Each macro builds one labeled concurrent assertion that reports by $error.
`ifndef PARTIAL_PERMUTATION_RANK_DEFINES_SVH
`define PARTIAL_PERMUTATION_RANK_DEFINES_SVH

// Same-cycle implication, disabled while rst is high.
`define PPR_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("partial_permutation_rank: assertion failed");

// Next-cycle implication, disabled while rst is high.
`define PPR_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("partial_permutation_rank: assertion failed");

`endif

/* rtl/ppr_pkg.sv */
// Package of the partial permutation ranker: widths, defaults, register codes
// and the beat payload types. Depends on nothing.
package ppr_pkg;

   localparam int MAX_TILES_DEF   = 9;
   localparam int BOARD_CELLS_DEF = 16;
   localparam int INPUT_FIELDS    = 9;
   localparam int POS_W           = 4;
   localparam int INDEX_W         = 32;
   localparam int PEBBLE_W        = 4;
   localparam int CSR_DATA_W      = 32;
   localparam int CSR_ADDR_W      = 3;

   localparam logic [PEBBLE_W-1:0]   PEBBLE_RESET          = 4'd9;
   localparam logic [CSR_ADDR_W-1:0] CSR_PEBBLE_COUNT_ADDR = 3'd0;

   typedef logic [POS_W-1:0] pos_type;

   typedef struct packed {
      pos_type tile_pos_0;
      pos_type tile_pos_1;
      pos_type tile_pos_2;
      pos_type tile_pos_3;
      pos_type tile_pos_4;
      pos_type tile_pos_5;
      pos_type tile_pos_6;
      pos_type tile_pos_7;
      pos_type tile_pos_8;
   } tile_req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] table_index;
   } rank_rsp_type;

endpackage

/* rtl/ppr_chan_if.sv */
// Valid/ready channel interface used for the request and response beats.
// The payload type is a parameter; the ranker uses the types of ppr_pkg.
interface ppr_chan_if #(
   parameter type payload_type = logic
) ();

   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);

endinterface

/* rtl/ppr_csr.sv */
// APB-style register block of the ranker: holds pebble_count and hands the
// clamped tile count to the cell chain. Depends on ppr_pkg.
module ppr_csr import ppr_pkg::*; #(
   parameter int MAX_TILES   = MAX_TILES_DEF,
   parameter int BOARD_CELLS = BOARD_CELLS_DEF,
   localparam int CNT_W      = $clog2(MAX_TILES + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output logic [CNT_W-1:0]      tile_count
);

   localparam int K_MAX = (MAX_TILES < BOARD_CELLS) ? MAX_TILES : BOARD_CELLS;

   logic [PEBBLE_W-1:0] pebble_ff;
   logic [PEBBLE_W-1:0] pebble_in;
   logic                wr_hit;

   assign pready = 1'b1;
   assign wr_hit = psel && penable && pwrite && (paddr == CSR_PEBBLE_COUNT_ADDR);

   always_comb begin
      pebble_in = pebble_ff;
      if (wr_hit) begin
         pebble_in = pwdata[PEBBLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pebble_ff <= PEBBLE_RESET;
      end else begin
         pebble_ff <= pebble_in;
      end
   end

   assign prdata = (paddr == CSR_PEBBLE_COUNT_ADDR)
                 ? {{(CSR_DATA_W-PEBBLE_W){1'b0}}, pebble_ff} : '0;

   // A count of zero ranks one tile; counts above the smaller of the chain length and BOARD_CELLS saturate.
   always_comb begin
      if (pebble_ff == '0) begin
         tile_count = CNT_W'(1);
      end else if (int'(pebble_ff) > K_MAX) begin
         tile_count = CNT_W'(K_MAX);
      end else begin
         tile_count = CNT_W'(pebble_ff);
      end
   end

endmodule

/* rtl/ppr_cell.sv */
// One cell of the ranking chain: while its index is below the tile count it folds the digit
// of its own tile into the running index by one Horner step; it registers the beat. Depends on ppr_pkg.
module ppr_cell import ppr_pkg::*; #(
   parameter int MAX_TILES   = MAX_TILES_DEF,
   parameter int BOARD_CELLS = BOARD_CELLS_DEF,
   parameter int CELL_IDX    = 0,
   localparam int CNT_W      = $clog2(MAX_TILES + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [CNT_W-1:0]                    tile_count,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic [INDEX_W-1:0]                  in_acc,
   input  logic [MAX_TILES-1:0][POS_W-1:0]     in_pos,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic [INDEX_W-1:0]                  out_acc,
   output logic [MAX_TILES-1:0][POS_W-1:0]     out_pos
);

   localparam logic [INDEX_W-1:0] FACTOR =
      (BOARD_CELLS > CELL_IDX) ? INDEX_W'(BOARD_CELLS - CELL_IDX) : '0;

   logic                            valid_ff;
   logic                            valid_in;
   logic [INDEX_W-1:0]              acc_ff;
   logic [INDEX_W-1:0]              acc_in;
   logic [MAX_TILES-1:0][POS_W-1:0] pos_ff;
   logic [MAX_TILES-1:0]            lt_vec;
   logic [CNT_W-1:0]                less_cnt;
   logic [INDEX_W-1:0]              digit;
   logic [INDEX_W-1:0]              scaled;
   logic                            active;
   logic                            load;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   // Digit: own cell minus the earlier tiles that sit on a lower cell.
   always_comb begin
      lt_vec = '0;
      for (int j = 0; j < MAX_TILES; j++) begin
         if (j < CELL_IDX && in_pos[j] < in_pos[CELL_IDX]) begin
            lt_vec[j] = 1'b1;
         end
      end
      less_cnt = CNT_W'($countones(lt_vec));
      digit    = INDEX_W'(in_pos[CELL_IDX]) - INDEX_W'(less_cnt);
      scaled   = in_acc * FACTOR;
      active   = tile_count > CNT_W'(CELL_IDX);
      acc_in   = active ? scaled + digit : in_acc;
   end

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         acc_ff <= acc_in;
         pos_ff <= in_pos;
      end
   end

   assign out_valid = valid_ff;
   assign out_acc   = acc_ff;
   assign out_pos   = pos_ff;

endmodule

/* rtl/partial_permutation_rank.sv */
// Throughput: one beat per cycle unless the response stalls; the chain of MAX_TILES cells
// advances every cycle it can.
// Each cell holds a register stage, so the length of the chain sets the latency.
// Reset (synchronous, active high) empties every cell and sets pebble_count to 9.
// Configuration registers: pebble_count at byte address 0.
module partial_permutation_rank import ppr_pkg::*; #(
   parameter int MAX_TILES   = MAX_TILES_DEF,
   parameter int BOARD_CELLS = BOARD_CELLS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   ppr_chan_if.sink              req_if,
   ppr_chan_if.source            rsp_if,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int CNT_W = $clog2(MAX_TILES + 1);

   // The rank is computed in Horner form. With k tiles and B board cells,
   //    index = (...((d0 * (B-1) + d1) * (B-2) + d2) ...) * (B-k+1) + d(k-1)
   // which expands to the mixed-radix sum of digit times weight. Cell i
   // multiplies the running index by (B-i) and adds its own digit; cells at
   // or beyond the tile count pass the index through unchanged. All
   // arithmetic wraps at 32 bits, which matches a sum taken modulo 2^32.

   logic [CNT_W-1:0]                tile_count;
   logic [POS_W-1:0]                field_pos [INPUT_FIELDS];
   logic                            valid_c [MAX_TILES+1];
   logic                            ready_c [MAX_TILES+1];
   logic [INDEX_W-1:0]              acc_c   [MAX_TILES+1];
   logic [MAX_TILES-1:0][POS_W-1:0] pos_c   [MAX_TILES+1];

   ppr_csr #(
      .MAX_TILES   (MAX_TILES),
      .BOARD_CELLS (BOARD_CELLS)
   ) u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (csr_psel),
      .penable    (csr_penable),
      .pwrite     (csr_pwrite),
      .paddr      (csr_paddr),
      .pwdata     (csr_pwdata),
      .prdata     (csr_prdata),
      .pready     (csr_pready),
      .tile_count (tile_count)
   );

   assign field_pos[0] = req_if.data.tile_pos_0;
   assign field_pos[1] = req_if.data.tile_pos_1;
   assign field_pos[2] = req_if.data.tile_pos_2;
   assign field_pos[3] = req_if.data.tile_pos_3;
   assign field_pos[4] = req_if.data.tile_pos_4;
   assign field_pos[5] = req_if.data.tile_pos_5;
   assign field_pos[6] = req_if.data.tile_pos_6;
   assign field_pos[7] = req_if.data.tile_pos_7;
   assign field_pos[8] = req_if.data.tile_pos_8;

   // The head of the chain sees the request beat directly. Tiles past the
   // last input field read as cell zero.
   assign valid_c[0]    = req_if.valid;
   assign req_if.ready  = ready_c[0];
   assign acc_c[0]      = '0;

   for (genvar t = 0; t < MAX_TILES; t++) begin : g_head
      if (t < INPUT_FIELDS) begin : g_field
         assign pos_c[0][t] = field_pos[t];
      end else begin : g_zero
         assign pos_c[0][t] = '0;
      end
   end

   // Each cell stalls only when its own register is full and the next cell
   // cannot take it, so bubbles collapse and the chain keeps accepting.
   for (genvar c = 0; c < MAX_TILES; c++) begin : g_cell
      ppr_cell #(
         .MAX_TILES   (MAX_TILES),
         .BOARD_CELLS (BOARD_CELLS),
         .CELL_IDX    (c)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .tile_count (tile_count),
         .in_valid   (valid_c[c]),
         .in_ready   (ready_c[c]),
         .in_acc     (acc_c[c]),
         .in_pos     (pos_c[c]),
         .out_valid  (valid_c[c+1]),
         .out_ready  (ready_c[c+1]),
         .out_acc    (acc_c[c+1]),
         .out_pos    (pos_c[c+1])
      );
   end

   // The last cell's register is the response register.
   assign rsp_if.valid            = valid_c[MAX_TILES];
   assign ready_c[MAX_TILES]      = rsp_if.ready;
   assign rsp_if.data.table_index = acc_c[MAX_TILES];

endmodule

/* rtl/ppr_checker.sv */
// Port-level checker of the partial permutation ranker, bound to the top level.
// Depends on ppr_pkg and partial_permutation_rank_defines.svh.
`include "partial_permutation_rank_defines.svh"

module ppr_checker import ppr_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [INDEX_W-1:0]    rsp_index,
   input logic                  csr_psel,
   input logic                  csr_penable,
   input logic                  csr_pwrite,
   input logic [CSR_ADDR_W-1:0] csr_paddr,
   input logic [CSR_DATA_W-1:0] csr_pwdata,
   input logic [CSR_DATA_W-1:0] csr_prdata
);

   logic csr_wr_count;

   assign csr_wr_count = csr_psel && csr_penable && csr_pwrite
                      && (csr_paddr == CSR_PEBBLE_COUNT_ADDR);

   // Reset leaves no response pending.
   `PPR_ASSERT_NXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

   // A taken response frees the whole chain, so a request can enter too.
   `PPR_ASSERT_IMP(a_ready_chain, clock, 1'b0, rsp_ready && !reset && req_valid, req_ready)

   // A stalled response keeps its beat.
   `PPR_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_index))

   // The pebble count reads back as written, with the upper bits zero.
   `PPR_ASSERT_IMP(a_csr_readback, clock, reset, csr_wr_count ##1 (csr_paddr == CSR_PEBBLE_COUNT_ADDR), (csr_prdata[PEBBLE_W-1:0] == $past(csr_pwdata[PEBBLE_W-1:0])) && (csr_prdata[CSR_DATA_W-1:PEBBLE_W] == '0))

endmodule

bind partial_permutation_rank ppr_checker u_ppr_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_if.valid),
   .req_ready   (req_if.ready),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_index   (rsp_if.data.table_index),
   .csr_psel    (csr_psel),
   .csr_penable (csr_penable),
   .csr_pwrite  (csr_pwrite),
   .csr_paddr   (csr_paddr),
   .csr_pwdata  (csr_pwdata),
   .csr_prdata  (csr_prdata)
);
